// ===== hdl/tis_pkg.sv =====
package tis_pkg;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 6;

    // default table size
    localparam int TIS_CAPACITY = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LINK,
        ST_EMIT_START,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } t_state;

endpackage

// ===== hdl/table_insertion_sort.sv =====
// insert: empty table: written from idle; else walk k entries (1..CAPACITY-1), then relink
// throughput: one request at a time; the walk reads one value and link and does one compare a cycle
// last request: emit start, then load and wait per sorted result; wait holds while the sink stalls
// head, fill count and overflow flag clear at the edge that takes the final result
// reset (synchronous, active low) clears control state; tables are not cleared
module table_insertion_sort
    import tis_pkg::*;
#(
    parameter int CAPACITY = TIS_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic [SLOT_W-1:0]         o_slot,
    output logic                      o_end_of_run,
    output logic                      o_overflow
);

    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [LINK_W-1:0] LINK_CAP  = LINK_W'(CAPACITY);
    localparam logic [LINK_W-1:0] LINK_ONE  = LINK_W'(1);
    localparam logic [LINK_W-1:0] LINK_NONE = '0;

    t_state r_state, n_state;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_fill, n_fill;
    logic              r_dropped, n_dropped;
    logic              r_last, n_last;
    logic signed [VALUE_W-1:0] r_key, n_key;
    logic              r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_end, n_out_end;
    logic              r_out_ovf, n_out_ovf;

    logic              accept;
    logic [LINK_W-1:0] slot;
    logic              val_we;
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [VALUE_W-1:0] rd_val;
    logic [LINK_W-1:0] rd_link;

    assign accept  = i_valid && o_ready;
    assign slot    = r_fill + LINK_ONE;
    // read data always belongs to the entry held in r_cur
    assign rd_addr = ADDR_W'(n_cur - LINK_ONE);

    // value and link tables
    tis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_val)
    );

    tis_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_prev      <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_dropped   <= n_dropped;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_out_value <= n_out_value;
        r_out_slot  <= n_out_slot;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
    end

    // sequencer: insert walk, relink, sorted readout
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_head      = r_head;
        n_fill      = r_fill;
        n_dropped   = r_dropped;
        n_last      = r_last;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_slot  = r_out_slot;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        val_we      = 1'b0;
        link_we     = 1'b0;
        link_waddr  = r_fill[ADDR_W-1:0];
        link_wdata  = LINK_NONE;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key  = i_value;
                    n_last = i_last_item;
                    if (r_fill < LINK_CAP) begin
                        val_we = 1'b1;
                        n_prev = LINK_NONE;
                        n_cur  = r_head;
                        if (r_head == LINK_NONE) begin
                            // empty list: new entry becomes the whole list
                            link_we = 1'b1;
                            n_head  = slot;
                            n_fill  = slot;
                            n_state = i_last_item ? ST_EMIT_START : ST_IDLE;
                        end else begin
                            n_state = ST_WALK;
                        end
                    end else begin
                        // table full: drop and flag
                        n_dropped = 1'b1;
                        n_state   = i_last_item ? ST_EMIT_START : ST_IDLE;
                    end
                end
            end

            ST_WALK: begin
                if (rd_val < r_key) begin
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    if (rd_link == LINK_NONE) begin
                        // append at the tail
                        link_we = 1'b1;
                        n_state = ST_LINK;
                    end
                end else begin
                    // insert ahead of the current entry
                    link_we    = 1'b1;
                    link_wdata = r_cur;
                    n_state    = ST_LINK;
                end
            end

            ST_LINK: begin
                if (r_prev == LINK_NONE) begin
                    n_head = slot;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = ADDR_W'(r_prev - LINK_ONE);
                    link_wdata = slot;
                end
                n_fill  = slot;
                n_state = r_last ? ST_EMIT_START : ST_IDLE;
            end

            ST_EMIT_START: begin
                n_cur = r_head;
                if (r_head == LINK_NONE) begin
                    n_head    = LINK_NONE;
                    n_fill    = LINK_NONE;
                    n_dropped = 1'b0;
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_EMIT_LOAD;
                end
            end

            ST_EMIT_LOAD: begin
                n_out_valid = 1'b1;
                n_out_value = rd_val;
                n_out_slot  = SLOT_W'(r_cur);
                n_out_end   = (rd_link == LINK_NONE);
                n_out_ovf   = r_dropped;
                n_cur       = rd_link;
                n_state     = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_end) begin
                        // run done: reset head, fill count and drop flag
                        n_head    = LINK_NONE;
                        n_fill    = LINK_NONE;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT_LOAD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_slot         = r_out_slot;
    assign o_end_of_run   = r_out_end;
    assign o_overflow     = r_out_ovf;

    // fill count stays within the table
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LINK_CAP)
        else $error("fill count beyond capacity");

    // empty list and zero fill go together
    a_head_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == LINK_NONE) == (r_fill == LINK_NONE))
        else $error("head pointer and fill count disagree");

    // walk only runs on a live entry
    a_walk_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cur != LINK_NONE))
        else $error("walk on end of list");

    // no new request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken during readout");

    // table is cleared after the final result
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_end_of_run) |=>
            (r_fill == LINK_NONE && !r_dropped && r_state == ST_IDLE))
        else $error("table not cleared after run");

endmodule

// ===== hdl/tis_ram.sv =====
module tis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
